// ===== design/rgbxt_pkg.sv =====
// Package for the RGB to xterm palette index core: widths, palette tables,
// candidate type and the small helper functions of the search.
// Depends on nothing; used by rgb_to_xterm_palette_index_core.
package rgbxt_pkg;

  localparam int CH_W  = 8;
  localparam int IDX_W = 8;
  // Largest squared distance is 3 * 255 * 255 = 195075, which fits in 18 bits.
  localparam int DIST_W = 18;
  // Constant products of the distance expansion are formed at this width.
  localparam int ACC_W = 20;

  localparam int PALETTE_ENTRIES = 254;
  localparam int BASE_COUNT      = 16;
  localparam int GREY_FIRST      = 232;
  localparam int GREY_COUNT      = PALETTE_ENTRIES - GREY_FIRST;
  localparam int GREY_LANES      = (GREY_COUNT > 0) ? GREY_COUNT : 1;

  // Candidate lanes: the basic colors, one lane for the best cube entry,
  // then the grey steps, so lane order follows palette index order.
  localparam int CUBE_LANE  = BASE_COUNT;
  localparam int GREY_LANE0 = BASE_COUNT + 1;
  localparam int N_LANES    = GREY_LANE0 + GREY_LANES;
  localparam int N_RED1     = (N_LANES + 3) / 4;
  localparam int N_RED2     = (N_RED1 + 3) / 4;

  localparam logic [IDX_W-1:0] CUBE_BASE = IDX_W'(16);

  // Basic colors, red in the top byte.
  localparam logic [3*CH_W-1:0] BASE_RGB [BASE_COUNT] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  localparam logic [CH_W-1:0] CUBE_LEVEL [6] = '{
    8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF
  };

  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  // Never wins against a real distance, since replacement needs strictly less.
  localparam cand_t CAND_PAD = '{sq_dist: '1, idx: '0};

  function automatic logic [CH_W-1:0] grey_level(input int j);
    return CH_W'((8 + j * 10) & 255);
  endfunction

  // Color of a fixed lane (basic color or grey step), red in the top byte.
  function automatic logic [3*CH_W-1:0] fixed_rgb(input int lane);
    logic [CH_W-1:0] g;
    g = grey_level(lane - GREY_LANE0);
    if (lane < BASE_COUNT) begin
      return BASE_RGB[lane];
    end
    return {g, g, g};
  endfunction

  // Nearest cube level of one component; a tie goes to the lower level.
  function automatic logic [2:0] cube_pick(input logic [CH_W-1:0] x);
    priority if (x <= 8'd47) begin
      return 3'd0;
    end else if (x <= 8'd115) begin
      return 3'd1;
    end else if (x <= 8'd155) begin
      return 3'd2;
    end else if (x <= 8'd195) begin
      return 3'd3;
    end else if (x <= 8'd235) begin
      return 3'd4;
    end else begin
      return 3'd5;
    end
  endfunction

  // Best of four candidates given in index order; the earlier one wins a tie.
  function automatic cand_t pick4(input cand_t a, input cand_t b,
                                  input cand_t c, input cand_t d);
    cand_t ab;
    cand_t cd;
    ab = (b.sq_dist < a.sq_dist) ? b : a;
    cd = (d.sq_dist < c.sq_dist) ? d : c;
    return (cd.sq_dist < ab.sq_dist) ? cd : ab;
  endfunction

endpackage

// ===== design/rgb_to_xterm_palette_index_core.sv =====
// Top level of the RGB to xterm palette index core: a six-stage pipeline
// that finds the nearest palette entry of one color per clock unless the output stalls.
// Depends on rgbxt_pkg.
//
// Usage:
//   Input items arrive on the s_ channel (s_tvalid, s_tready, s_tdata) and
//   carry one 24-bit color: red in bits 7:0, green in 15:8, blue in 23:16.
//   Result items leave on the m_ channel and carry the palette index in
//   m_tdata[7:0]. Every input item gives exactly one result item, in order.
//   The register use_256_colors is written through cfg_wen / cfg_wdata; at 0
//   the index is reduced modulo 16, at 1 the full index is returned. It is
//   meant to be written only while no item is in flight.
//   An accepted input item passes through the stage registers v1 to v5 and
//   then raises m_tvalid with its result. The block takes one item in every
//   cycle while the receiver takes results; the rate is set by the pipeline,
//   whose stages each hold one item.
//   Each stage advances when it is empty or the stage after it advances, so
//   when the receiver holds m_tready low the result is held, bubbles inside
//   the pipeline are filled first, and s_tready falls only once all six
//   stages hold items. Nothing is dropped or repeated across a stall.
//   Reset (rst, synchronous, active high) empties the pipeline and clears
//   use_256_colors to 0.
//
// Stages: 1 registers the color; 2 holds the sum of squares and the nearest
// cube entry per component; 3 holds one exact distance per candidate lane
// (basic colors, best cube entry, grey steps); 4, 5 and 6 are 4-to-1
// minimum trees that keep the lower index on a tie.
module rgb_to_xterm_palette_index_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // color_index [7:0]
  input  logic        cfg_wen,
  input  logic        cfg_wdata  // use_256_colors
);

  localparam int CW = rgbxt_pkg::CH_W;
  localparam int DW = rgbxt_pkg::DIST_W;
  localparam int AW = rgbxt_pkg::ACC_W;
  localparam int IW = rgbxt_pkg::IDX_W;

  // Configuration register.
  logic use_256;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_256 <= 1'b0;
    end else if (cfg_wen) begin
      use_256 <= cfg_wdata;
    end
  end

  // Stage valid bits and advance enables. A stage loads when it is empty or
  // its content moves on in the same cycle.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = !m_tvalid || m_tready;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) m_tvalid <= v5;
    end
  end

  // Stage 1: input color.
  logic [CW-1:0] r1, g1, b1;

  always_ff @(posedge clk) begin
    if (en1) begin
      r1 <= s_tdata[7:0];
      g1 <= s_tdata[15:8];
      b1 <= s_tdata[23:16];
    end
  end

  // Stage 2: sum of squares of the color, and the nearest cube entry.
  // The cube distance separates per component, so the nearest level of each
  // component (lower level on a tie) gives the lowest-index nearest entry.
  logic [CW-1:0] r2, g2, b2;
  logic [DW-1:0] q2;
  logic [IW-1:0] cube_idx2;
  logic [CW-1:0] cdr2, cdg2, cdb2;

  logic [DW-1:0] q_next;
  logic [IW-1:0] cube_idx_next;
  logic [CW-1:0] cdr_next, cdg_next, cdb_next;

  always_comb begin
    logic [2:0]    ri, gi, bi;
    logic [CW-1:0] lr, lg, lb;
    q_next = DW'(r1) * DW'(r1) + DW'(g1) * DW'(g1) + DW'(b1) * DW'(b1);
    ri = rgbxt_pkg::cube_pick(r1);
    gi = rgbxt_pkg::cube_pick(g1);
    bi = rgbxt_pkg::cube_pick(b1);
    lr = rgbxt_pkg::CUBE_LEVEL[ri];
    lg = rgbxt_pkg::CUBE_LEVEL[gi];
    lb = rgbxt_pkg::CUBE_LEVEL[bi];
    cdr_next = (r1 > lr) ? (r1 - lr) : (lr - r1);
    cdg_next = (g1 > lg) ? (g1 - lg) : (lg - g1);
    cdb_next = (b1 > lb) ? (b1 - lb) : (lb - b1);
    cube_idx_next = rgbxt_pkg::CUBE_BASE + IW'(ri) * IW'(36) + IW'(gi) * IW'(6) + IW'(bi);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      r2        <= r1;
      g2        <= g1;
      b2        <= b1;
      q2        <= q_next;
      cube_idx2 <= cube_idx_next;
      cdr2      <= cdr_next;
      cdg2      <= cdg_next;
      cdb2      <= cdb_next;
    end
  end

  // Stage 3: exact distance of every candidate lane. For a fixed color c the
  // distance is |c|^2 + |x|^2 - 2 c.x, which needs only constant products.
  rgbxt_pkg::cand_t cand3 [rgbxt_pkg::N_LANES];
  rgbxt_pkg::cand_t cand3_next [rgbxt_pkg::N_LANES];

  always_comb begin
    logic [3*CW-1:0] rgb;
    logic [AW-1:0]   cr, cg, cb;
    logic [AW-1:0]   acc;
    for (int k = 0; k < rgbxt_pkg::N_LANES; k++) begin
      rgb = rgbxt_pkg::fixed_rgb(k);
      cr  = AW'(rgb[23:16]);
      cg  = AW'(rgb[15:8]);
      cb  = AW'(rgb[7:0]);
      acc = cr * cr + cg * cg + cb * cb + AW'(q2)
            - AW'(2) * cr * AW'(r2) - AW'(2) * cg * AW'(g2) - AW'(2) * cb * AW'(b2);
      if (k == rgbxt_pkg::CUBE_LANE) begin
        cand3_next[k].sq_dist = DW'(cdr2) * DW'(cdr2) + DW'(cdg2) * DW'(cdg2)
                                + DW'(cdb2) * DW'(cdb2);
        cand3_next[k].idx     = cube_idx2;
      end else if (k < rgbxt_pkg::BASE_COUNT) begin
        cand3_next[k].sq_dist = acc[DW-1:0];
        cand3_next[k].idx     = IW'(k);
      end else if (k - rgbxt_pkg::GREY_LANE0 < rgbxt_pkg::GREY_COUNT) begin
        cand3_next[k].sq_dist = acc[DW-1:0];
        cand3_next[k].idx     = IW'(rgbxt_pkg::GREY_FIRST + k - rgbxt_pkg::GREY_LANE0);
      end else begin
        // Only reached when the palette has no grey steps at all.
        cand3_next[k] = rgbxt_pkg::CAND_PAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cand3 <= cand3_next;
    end
  end

  // Stage 4: first minimum tree level, groups of four lanes.
  rgbxt_pkg::cand_t cand4 [rgbxt_pkg::N_RED1];
  rgbxt_pkg::cand_t cand4_next [rgbxt_pkg::N_RED1];

  always_comb begin
    rgbxt_pkg::cand_t grp [4];
    for (int m = 0; m < rgbxt_pkg::N_RED1; m++) begin
      for (int n = 0; n < 4; n++) begin
        grp[n] = (4 * m + n < rgbxt_pkg::N_LANES) ? cand3[4 * m + n] : rgbxt_pkg::CAND_PAD;
      end
      cand4_next[m] = rgbxt_pkg::pick4(grp[0], grp[1], grp[2], grp[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      cand4 <= cand4_next;
    end
  end

  // Stage 5: second minimum tree level.
  rgbxt_pkg::cand_t cand5 [rgbxt_pkg::N_RED2];
  rgbxt_pkg::cand_t cand5_next [rgbxt_pkg::N_RED2];

  always_comb begin
    rgbxt_pkg::cand_t grp [4];
    for (int m = 0; m < rgbxt_pkg::N_RED2; m++) begin
      for (int n = 0; n < 4; n++) begin
        grp[n] = (4 * m + n < rgbxt_pkg::N_RED1) ? cand4[4 * m + n] : rgbxt_pkg::CAND_PAD;
      end
      cand5_next[m] = rgbxt_pkg::pick4(grp[0], grp[1], grp[2], grp[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      cand5 <= cand5_next;
    end
  end

  // Stage 6: last tree level and the 16-color reduction into the output
  // register.
  logic [IW-1:0] index_next;

  always_comb begin
    rgbxt_pkg::cand_t grp [4];
    rgbxt_pkg::cand_t best;
    for (int n = 0; n < 4; n++) begin
      grp[n] = (n < rgbxt_pkg::N_RED2) ? cand5[n] : rgbxt_pkg::CAND_PAD;
    end
    best       = rgbxt_pkg::pick4(grp[0], grp[1], grp[2], grp[3]);
    index_next = use_256 ? best.idx : {4'b0000, best.idx[3:0]};
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      m_tdata <= index_next;
    end
  end

  // Assertions.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled although the receiver takes results");

  a_index_in_palette: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(m_tdata) < rgbxt_pkg::PALETTE_ENTRIES))
    else $error("result index beyond the palette");

  a_cube_in_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (cube_idx2 >= rgbxt_pkg::CUBE_BASE && int'(cube_idx2) < rgbxt_pkg::GREY_FIRST))
    else $error("cube candidate outside the cube");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid && !v1 && !v5)
    else $error("pipeline not empty after reset");

  a_stall_holds_stage5: assert property (@(posedge clk) disable iff (rst)
    v5 && !en6 |=> v5 && m_tvalid)
    else $error("item lost while the output stalls");

endmodule

// ===== test/xterm_index_checker.sv =====
`timescale 1ns / 1ps
// Checker for the RGB to xterm palette index core: watches both stream channels
// and the register port, predicts each color's palette index and compares.
// Depends on nothing but the port list of rgb_to_xterm_palette_index_core.
module xterm_index_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // color_index [7:0]
  input  logic        cfg_wen,
  input  logic        cfg_wdata, // use_256_colors
  output int          mismatches,
  output int          outstanding
);

  localparam int PALETTE_SIZE = 254;
  localparam int MAX_REPORTS  = 10;

  // The sixteen basic colors, red in the top byte.
  localparam logic [23:0] BASIC_COLORS [16] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };
  localparam logic [7:0] CUBE_STEPS [6] = '{8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF};

  logic [7:0] expected_idx [$];
  logic       full_palette = 1'b0;
  int         err_count = 0;

  function automatic logic [23:0] palette_rgb(input int idx);
    logic [7:0] grey;
    int k;
    k    = idx - 16;
    grey = 8'((8 + (idx - 232) * 10) & 255);
    if (idx < 16) begin
      return BASIC_COLORS[idx];
    end else if (idx < 232) begin
      return {CUBE_STEPS[(k / 36) % 6], CUBE_STEPS[(k / 6) % 6], CUBE_STEPS[k % 6]};
    end
    return {grey, grey, grey};
  endfunction

  // Full search in index order; a later entry wins only when strictly nearer.
  function automatic logic [7:0] nearest_palette_index(input logic [7:0] r,
                                                       input logic [7:0] g,
                                                       input logic [7:0] b,
                                                       input logic full);
    logic [23:0] c;
    int best;
    int best_dist;
    int d;
    best      = 0;
    best_dist = 0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      c = palette_rgb(i);
      d = (int'(c[23:16]) - int'(r)) ** 2 + (int'(c[15:8]) - int'(g)) ** 2
        + (int'(c[7:0]) - int'(b)) ** 2;
      if (i == 0 || d < best_dist) begin
        best_dist = d;
        best      = i;
      end
    end
    if (!full) begin
      best = best % 16;
    end
    return 8'(best);
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    if (err_count < MAX_REPORTS) begin
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    end
    err_count++;
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      expected_idx.delete();
      full_palette = 1'b0;
      outstanding <= 0;
    end else begin
      // Results are checked before the item of this same edge is predicted.
      if (m_tvalid && m_tready) begin
        if (expected_idx.size() == 0) begin
          note_mismatch("result item with none pending", -1, m_tdata);
        end else begin
          want = expected_idx.pop_front();
          if (m_tdata !== want) begin
            note_mismatch("color_index", want, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_idx.push_back(nearest_palette_index(s_tdata[7:0], s_tdata[15:8],
                                                     s_tdata[23:16], full_palette));
      end
      if (cfg_wen) begin
        full_palette = cfg_wdata;
      end
      outstanding <= expected_idx.size();
    end
    mismatches <= err_count;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the RGB to xterm palette index core: clock, reset,
// stimulus, receiver stalls and the verdict. Depends on the core and on
// xterm_index_checker, which predicts and compares every result item.
module tb_top;

  localparam int  ITEMS_PER_PHASE = 225;
  localparam int  RANDOM_PHASES   = 4;
  localparam int  SETTLE_CYCLES   = 10;
  localparam real RUN_LIMIT_NS    = 10_000_000.0;

  // Receiver behaviors; each holds for a random stretch of cycles.
  typedef enum int {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_LONG_STALL
  } rx_pattern_e;

  // Every input starts at a known value; afterwards all are driven at the edge.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_wen   = 1'b0;
  logic        cfg_wdata = 1'b0;

  int mismatches;
  int outstanding;

  int          burst_left = 0;
  rx_pattern_e rx_pattern = RX_ALWAYS;
  int          rx_left    = 0;

  localparam logic [7:0] CUBE_STEPS [6]   = '{8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF};
  // Channel values where two neighboring cube steps are equally near or
  // nearly so; colors built from them probe the lowest-index-wins rule.
  localparam logic [7:0] CUBE_BOUNDS [10] = '{8'd47, 8'd48, 8'd115, 8'd116, 8'd155,
                                              8'd156, 8'd195, 8'd196, 8'd235, 8'd236};

  always #5 clk = ~clk;

  rgb_to_xterm_palette_index_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  xterm_index_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The receiver switches between patterns: always ready, ready about half
  // the time, rarely ready, and a long stall that opens only near the end of
  // its stretch. The long stall lets the pipeline fill so that s_tready falls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
      rx_left    <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_pattern)
      RX_ALWAYS:     m_tready <= 1'b1;
      RX_HALF:       m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:     m_tready <= ($urandom_range(0, 3) == 0);
      RX_LONG_STALL: m_tready <= (rx_left < 4);
      default:       m_tready <= 1'b1;
    endcase
  end

  // Presents one color and holds it until the core accepts it. The sender
  // works in bursts; between bursts tvalid may drop for a random gap. Within a
  // burst tvalid stays high from one item to the next.
  task automatic send_color(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops sending and waits until every predicted result has come back, then
  // lets the pipeline settle before anything else happens.
  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes use_256_colors; only called while nothing is in flight.
  task automatic write_palette_mode(input logic full);
    cfg_wen   <= 1'b1;
    cfg_wdata <= full;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic logic [7:0] jittered(input int center, input int spread);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return 8'(v);
  endfunction

  // One channel value: uniform, near a cube step, or near a cube boundary.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return jittered(CUBE_STEPS[$urandom_range(0, 5)], 3);
      default: return jittered(CUBE_BOUNDS[$urandom_range(0, 9)], 1);
    endcase
  endfunction

  // Random color: mostly independent channels; about one in five is a grey
  // or near-grey, which is where the grey steps compete with the cube.
  task automatic send_random_color();
    logic [7:0] v;
    if ($urandom_range(0, 4) == 0) begin
      v = pick_channel();
      send_color(v, jittered(v, 2), jittered(v, 2));
    end else begin
      send_color(pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed colors with the full palette index visible.
    write_palette_mode(1'b1);
    send_color(8'h00, 8'h00, 8'h00);  // black ties basic black and cube black
    send_color(8'hFF, 8'hFF, 8'hFF);  // white ties basic white and cube white
    send_color(8'hFF, 8'h00, 8'h00);
    send_color(8'h00, 8'hFF, 8'h00);
    send_color(8'h00, 8'h00, 8'hFF);
    send_color(8'hCD, 8'hCD, 8'h00);
    send_color(8'h00, 8'h00, 8'hEE);
    send_color(8'hE5, 8'hE5, 8'hE5);
    send_color(8'h7F, 8'h7F, 8'h7F);
    send_color(8'h5C, 8'h5C, 8'hFF);
    send_color(8'h2F, 8'h00, 8'h00);  // just below halfway between two cube steps
    send_color(8'h30, 8'h00, 8'h00);
    send_color(8'h08, 8'h08, 8'h08);  // first grey step
    send_color(8'hDA, 8'hDA, 8'hDA);  // last grey step
    send_color(8'h0D, 8'h0D, 8'h0D);  // equally near two grey steps
    send_color(8'h76, 8'h76, 8'h76);
    send_color(8'h80, 8'h80, 8'h80);
    send_color(8'h5F, 8'h87, 8'hAF);  // an exact cube entry
    send_color(8'hD7, 8'hFF, 8'h00);
    send_color(8'h12, 8'h34, 8'h56);
    send_color(8'hFE, 8'hDC, 8'hBA);
    send_color(8'hAA, 8'h55, 8'hAA);
    wait_drained();

    // Random phases alternate between 16-color and 256-color mode. Halfway
    // through the second phase the sender waits for every pending result.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_palette_mode(phase % 2 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        send_random_color();
      end
      wait_drained();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rgbxt_pkg.sv
design/rgb_to_xterm_palette_index_core.sv
test/xterm_index_checker.sv
test/tb_top.sv
